>>> rtl/infix_expression_syntax_checker_defines.svh
// Assertion macros for the infix expression syntax checker.
// Used by the bound port checker; expects clk and rst in the using scope.
`ifndef INFIX_EXPRESSION_SYNTAX_CHECKER_DEFINES_SVH
`define INFIX_EXPRESSION_SYNTAX_CHECKER_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define IESC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every clock edge, reset included.
`define IESC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/iesc_pkg.sv
// Shared types, status codes and character classes of the syntax checker.
// No dependencies.
package iesc_pkg;

  typedef logic [7:0] char_t;
  typedef logic [2:0] status_t;
  typedef logic [1:0] kind_t;

  localparam int STACK_DEPTH_DEF = 64;

  // Status codes
  localparam status_t ERR_OK        = 3'd0;
  localparam status_t ERR_OPENED    = 3'd1;
  localparam status_t ERR_FIRST     = 3'd2;
  localparam status_t ERR_SECOND    = 3'd3;
  localparam status_t ERR_OPERATION = 3'd4;
  localparam status_t ERR_INVALID   = 3'd5;
  localparam status_t ERR_CLOSED    = 3'd6;
  localparam status_t ERR_OVERFLOW  = 3'd7;

  // Bracket kinds; KIND_NONE means not a bracket
  localparam kind_t KIND_NONE  = 2'd0;
  localparam kind_t KIND_ROUND = 2'd1;
  localparam kind_t KIND_SQUARE = 2'd2;
  localparam kind_t KIND_CURLY = 2'd3;

  localparam char_t CH_LPAREN = 8'h28;
  localparam char_t CH_LBRACK = 8'h5B;
  localparam char_t CH_LBRACE = 8'h7B;
  localparam char_t CH_RPAREN = 8'h29;
  localparam char_t CH_RBRACK = 8'h5D;
  localparam char_t CH_RBRACE = 8'h7D;
  localparam char_t CH_PLUS   = 8'h2B;
  localparam char_t CH_MINUS  = 8'h2D;
  localparam char_t CH_STAR   = 8'h2A;
  localparam char_t CH_SLASH  = 8'h2F;
  localparam char_t CH_CARET  = 8'h5E;
  localparam char_t CH_SPACE  = 8'h20;
  localparam char_t CH_0 = 8'h30;
  localparam char_t CH_9 = 8'h39;
  localparam char_t CH_UA = 8'h41;
  localparam char_t CH_UZ = 8'h5A;
  localparam char_t CH_LA = 8'h61;
  localparam char_t CH_LZ = 8'h7A;

  function automatic logic is_ident(input char_t c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
           (c >= CH_LA && c <= CH_LZ);
  endfunction

  function automatic kind_t open_kind(input char_t c);
    kind_t k;
    unique case (c)
      CH_LPAREN: k = KIND_ROUND;
      CH_LBRACK: k = KIND_SQUARE;
      CH_LBRACE: k = KIND_CURLY;
      default:   k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic kind_t close_kind(input char_t c);
    kind_t k;
    unique case (c)
      CH_RPAREN: k = KIND_ROUND;
      CH_RBRACK: k = KIND_SQUARE;
      CH_RBRACE: k = KIND_CURLY;
      default:   k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic is_op(input char_t c);
    return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
           c == CH_CARET;
  endfunction

endpackage

>>> rtl/iesc_if.sv
// Valid/ready channel interfaces: character beats in, status beats out.
// Depends on iesc_pkg.
interface iesc_char_if;
  logic              valid;
  logic              ready;
  iesc_pkg::char_t   char_code;
  logic              last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface iesc_status_if;
  logic              valid;
  logic              ready;
  iesc_pkg::status_t status;
  logic              verdict;

  modport source (output valid, output status, output verdict, input ready);
  modport sink   (input valid, input status, input verdict, output ready);
endinterface

>>> rtl/iesc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module iesc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/infix_expression_syntax_checker.sv
// Streaming infix expression syntax checker, top level.
// Depends on iesc_pkg, iesc_char_if / iesc_status_if and iesc_ram.
//
//   channel  | dir | payload               | beat
//   ---------+-----+-----------------------+------------------------------
//   chars    | in  | char_code, last_char  | one expression character
//   results  | out | status, verdict       | one status per character
//
// One character is taken per cycle while the output is not stalled; its
// status beat shows in the output register in the cycle after. The stack
// keeps its top entry in a register and the rest in a RAM whose next-to-top
// entry is prefetched, so a pop finds the new top at hand. A stalled output
// holds its beat; a new character is taken in the cycle the held beat drains.
// The stack RAM needs no clearing at reset.
module infix_expression_syntax_checker #(
  parameter int STACK_DEPTH = iesc_pkg::STACK_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  iesc_char_if.sink            chars,
  iesc_status_if.source        results
);

  import iesc_pkg::*;

  localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
  // RAM holds every entry below the top one
  localparam int RAM_DEPTH = (STACK_DEPTH > 2) ? STACK_DEPTH - 1 : 2;
  localparam int ADDR_W    = $clog2(RAM_DEPTH);

  // Parser state
  logic [CNT_W-1:0] count;
  kind_t            top_kind;
  logic             operand_due;
  logic             in_identifier;
  logic             await_second;
  logic             invalid_waiting;
  status_t          latched_error;

  logic [CNT_W-1:0] count_next;
  kind_t            top_kind_next;
  logic             operand_due_next;
  logic             in_identifier_next;
  logic             await_second_next;
  logic             invalid_waiting_next;
  status_t          latched_error_next;

  // Output register
  logic    out_valid;
  status_t status;
  logic    verdict;
  status_t status_next;

  // Stack RAM and write-to-read bypass
  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [ADDR_W-1:0] ram_rd_addr;
  kind_t             ram_rd_data;
  logic              byp_valid;
  kind_t             byp_data;
  kind_t             below;

  // Character decode
  logic  accept;
  logic  c_ident;
  logic  c_op;
  kind_t c_open;
  kind_t c_close;
  logic  handled;
  logic  do_push;
  logic  do_pop;
  status_t err;
  logic [CNT_W-1:0] count_step;

  assign chars.ready = !out_valid || results.ready;
  assign accept      = chars.valid && chars.ready;

  assign c_ident = is_ident(chars.char_code);
  assign c_op    = is_op(chars.char_code);
  assign c_open  = open_kind(chars.char_code);
  assign c_close = close_kind(chars.char_code);

  // Entry just below the top, valid whenever count >= 2
  assign below = byp_valid ? byp_data : ram_rd_data;

  // Per-character decision; mirrors the order of checks for one character
  always_comb begin
    err                  = latched_error;
    handled              = 1'b0;
    do_push              = 1'b0;
    do_pop               = 1'b0;
    operand_due_next     = operand_due;
    in_identifier_next   = in_identifier;
    await_second_next    = await_second;
    invalid_waiting_next = invalid_waiting;
    if (latched_error == ERR_OK) begin
      if (chars.char_code == CH_SPACE) begin
        in_identifier_next = 1'b0;
      end else if (!(c_ident && in_identifier)) begin
        in_identifier_next = 1'b0;
        // Deferred resolution of what follows an operator
        if (await_second) begin
          if (c_ident || c_open != KIND_NONE) begin
            await_second_next = 1'b0;
            if (invalid_waiting) begin
              err     = ERR_INVALID;
              handled = 1'b1;
            end
          end else if (c_op || c_close != KIND_NONE) begin
            err     = ERR_SECOND;
            handled = 1'b1;
          end else begin
            invalid_waiting_next = 1'b1;
            handled              = 1'b1;
          end
        end
        if (!handled) begin
          if (c_open != KIND_NONE) begin
            if (count == CNT_W'(STACK_DEPTH)) begin
              err = ERR_OVERFLOW;
            end else begin
              do_push          = 1'b1;
              operand_due_next = 1'b1;
            end
          end else if (c_close != KIND_NONE) begin
            if (count == '0 || top_kind != c_close) begin
              err = ERR_OPENED;
            end else begin
              do_pop           = 1'b1;
              operand_due_next = 1'b0;
            end
          end else if (c_op) begin
            if (operand_due) begin
              err = ERR_FIRST;
            end else begin
              await_second_next    = 1'b1;
              invalid_waiting_next = 1'b0;
              operand_due_next     = 1'b1;
            end
          end else if (c_ident) begin
            if (!operand_due) begin
              err = ERR_OPERATION;
            end else begin
              in_identifier_next = 1'b1;
              operand_due_next   = 1'b0;
            end
          end else begin
            err = ERR_INVALID;
          end
        end
      end
    end
  end

  always_comb begin
    if (do_push) begin
      count_step = count + 1'b1;
    end else if (do_pop) begin
      count_step = count - 1'b1;
    end else begin
      count_step = count;
    end
  end

  // Final verdict folds in a dangling operator and unclosed brackets
  always_comb begin
    status_next = err;
    if (chars.last_char && err == ERR_OK) begin
      if (await_second_next) begin
        status_next = ERR_SECOND;
      end else if (count_step != '0) begin
        status_next = ERR_CLOSED;
      end
    end
  end

  always_comb begin
    count_next         = count;
    top_kind_next      = top_kind;
    latched_error_next = latched_error;
    if (accept) begin
      if (chars.last_char) begin
        count_next         = '0;
        latched_error_next = ERR_OK;
      end else begin
        count_next         = count_step;
        latched_error_next = err;
      end
      if (do_push) begin
        top_kind_next = c_open;
      end else if (do_pop) begin
        top_kind_next = below;
      end
    end
  end

  // Push spills the old top into the RAM; prefetch the entry below the next top
  assign ram_wr_en   = accept && do_push && count != '0;
  assign ram_wr_addr = ADDR_W'(count - 1'b1);
  assign ram_rd_addr = ADDR_W'(count_next - CNT_W'(2));

  iesc_ram #(
    .WIDTH ($bits(kind_t)),
    .DEPTH (RAM_DEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (top_kind),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    byp_valid <= ram_wr_en && (ram_wr_addr == ram_rd_addr);
    byp_data  <= top_kind;
    top_kind  <= top_kind_next;
    if (accept) begin
      status  <= status_next;
      verdict <= chars.last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count           <= '0;
      operand_due     <= 1'b1;
      in_identifier   <= 1'b0;
      await_second    <= 1'b0;
      invalid_waiting <= 1'b0;
      latched_error   <= ERR_OK;
      out_valid       <= 1'b0;
    end else begin
      count         <= count_next;
      latched_error <= latched_error_next;
      if (accept) begin
        if (chars.last_char) begin
          operand_due     <= 1'b1;
          in_identifier   <= 1'b0;
          await_second    <= 1'b0;
          invalid_waiting <= 1'b0;
        end else begin
          operand_due     <= operand_due_next;
          in_identifier   <= in_identifier_next;
          await_second    <= await_second_next;
          invalid_waiting <= invalid_waiting_next;
        end
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign results.valid   = out_valid;
  assign results.status  = status;
  assign results.verdict = verdict;

endmodule

>>> rtl/iesc_checker.sv
// Port-level assertions for the syntax checker, bound to the top level.
// Depends on iesc_pkg and infix_expression_syntax_checker_defines.svh.
`include "infix_expression_syntax_checker_defines.svh"

module iesc_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input iesc_pkg::status_t status,
  input logic              verdict
);

  import iesc_pkg::*;

  // Last delivered beat, and whether it left an expression open
  status_t prev_status;
  logic    prev_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_open   <= 1'b0;
      prev_status <= ERR_OK;
    end else if (out_valid && out_ready) begin
      prev_open   <= !verdict;
      prev_status <= status;
    end
  end

  `IESC_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result beat right after reset")
  `IESC_ASSERT(a_beat_follows, in_valid && in_ready |=> out_valid, "accepted char gave no beat")
  `IESC_ASSERT(a_no_overrun, in_valid && in_ready |-> !out_valid || out_ready, "beat overwritten")
  `IESC_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(verdict), "stalled beat changed")
  `IESC_ASSERT(a_error_latched, out_valid && out_ready && prev_open && prev_status != ERR_OK |-> status == prev_status, "latched error changed")

endmodule

bind infix_expression_syntax_checker iesc_checker u_iesc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (chars.valid),
  .in_ready  (chars.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .status    (results.status),
  .verdict   (results.verdict)
);

>>> verif/expr_status_checker.sv
// Status beat checker for the infix expression syntax checker: predicts each
// status beat from the accepted character beats and compares.
// Depends on iesc_pkg and the channel interfaces of iesc_if.sv.
module expr_status_checker #(
  parameter int STACK_DEPTH = iesc_pkg::STACK_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  iesc_char_if   chars,
  iesc_status_if results,
  output int     fail_count,
  output int     beats_owed
);
  import iesc_pkg::*;

  typedef struct packed {
    status_t status;
    logic    verdict;
  } status_beat_t;

  status_beat_t owed_beats[$];

  // Syntax state of the expression in flight
  kind_t   open_stack [STACK_DEPTH];
  int      depth;
  logic    want_operand;
  logic    in_name;
  logic    need_rhs;
  logic    junk_after_op;
  status_t first_err;

  function automatic kind_t opener_kind(input char_t c);
    case (c)
      CH_LPAREN: return KIND_ROUND;
      CH_LBRACK: return KIND_SQUARE;
      CH_LBRACE: return KIND_CURLY;
      default:   return KIND_NONE;
    endcase
  endfunction

  function automatic kind_t closer_kind(input char_t c);
    case (c)
      CH_RPAREN: return KIND_ROUND;
      CH_RBRACK: return KIND_SQUARE;
      CH_RBRACE: return KIND_CURLY;
      default:   return KIND_NONE;
    endcase
  endfunction

  function automatic logic is_name_char(input char_t c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
           (c >= CH_LA && c <= CH_LZ);
  endfunction

  function automatic logic is_binop(input char_t c);
    return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
           c == CH_CARET;
  endfunction

  function automatic void clear_expr();
    depth         = 0;
    want_operand  = 1'b1;
    in_name       = 1'b0;
    need_rhs      = 1'b0;
    junk_after_op = 1'b0;
    first_err     = ERR_OK;
  endfunction

  // One character with no error latched yet; returns the error it raises.
  function automatic status_t scan_char(input char_t c);
    kind_t ok;
    kind_t ck;
    logic  nm;
    ok = opener_kind(c);
    ck = closer_kind(c);
    nm = is_name_char(c);
    if (c == CH_SPACE) begin
      in_name = 1'b0;
      return ERR_OK;
    end
    if (nm && in_name) return ERR_OK;
    in_name = 1'b0;
    // Operator pending: junk is held back until the next real token decides
    if (need_rhs) begin
      if (nm || ok != KIND_NONE) begin
        need_rhs = 1'b0;
        if (junk_after_op) return ERR_INVALID;
      end else if (is_binop(c) || ck != KIND_NONE) begin
        return ERR_SECOND;
      end else begin
        junk_after_op = 1'b1;
        return ERR_OK;
      end
    end
    if (ok != KIND_NONE) begin
      if (depth >= STACK_DEPTH) return ERR_OVERFLOW;
      open_stack[depth] = ok;
      depth++;
      want_operand = 1'b1;
      return ERR_OK;
    end
    if (ck != KIND_NONE) begin
      if (depth == 0 || open_stack[depth - 1] != ck) return ERR_OPENED;
      depth--;
      want_operand = 1'b0;
      return ERR_OK;
    end
    if (is_binop(c)) begin
      if (want_operand) return ERR_FIRST;
      need_rhs      = 1'b1;
      junk_after_op = 1'b0;
      want_operand  = 1'b1;
      return ERR_OK;
    end
    if (nm) begin
      if (!want_operand) return ERR_OPERATION;
      in_name      = 1'b1;
      want_operand = 1'b0;
      return ERR_OK;
    end
    return ERR_INVALID;
  endfunction

  function automatic void predict_status(input char_t c, input logic fin);
    status_beat_t beat;
    if (first_err == ERR_OK) first_err = scan_char(c);
    beat.status  = first_err;
    beat.verdict = fin;
    if (fin) begin
      if (beat.status == ERR_OK) begin
        if (need_rhs) beat.status = ERR_SECOND;
        else if (depth != 0) beat.status = ERR_CLOSED;
      end
      clear_expr();
    end
    owed_beats.insert(owed_beats.size(), beat);
  endfunction

  always @(posedge clk) begin
    status_beat_t want;
    if (rst) begin
      clear_expr();
      owed_beats.delete();
      fail_count = 0;
    end else begin
      // A status beat always belongs to an earlier character, so compare first
      if (results.valid && results.ready) begin
        if (owed_beats.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected status beat status=%0d verdict=%0b",
                   $time, results.status, results.verdict);
        end else begin
          want = owed_beats.pop_front();
          if (results.status !== want.status) begin
            fail_count++;
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, results.status);
          end
          if (results.verdict !== want.verdict) begin
            fail_count++;
            $display("%0t: verdict expected %0b actual %0b",
                     $time, want.verdict, results.verdict);
          end
        end
      end
      if (chars.valid && chars.ready) predict_status(chars.char_code, chars.last_char);
    end
    beats_owed = owed_beats.size();
  end

endmodule

>>> verif/infix_expression_syntax_checker_tb.sv
// Top of the syntax checker bench: clock, reset, character stimulus and the
// status sink. Depends on iesc_pkg, iesc_if.sv, the RTL top and
// expr_status_checker, which does all prediction and comparison.
module infix_expression_syntax_checker_tb;
  import iesc_pkg::*;

  localparam char_t OPS [5]     = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};
  localparam char_t OPENERS [3] = '{CH_LPAREN, CH_LBRACK, CH_LBRACE};
  localparam char_t CLOSERS [3] = '{CH_RPAREN, CH_RBRACK, CH_RBRACE};

  // Hand-picked expressions covering each special case of the checker:
  // all operators and bracket kinds, bad closing, operator with no left side,
  // operator right after operator, adjacent operands, junk after an operator
  // resolved by an operand, by an operator and by the end, open brackets left
  // at the end, empty brackets and a lone one-character expression.
  string directed_exprs [] = '{
    "a+b", "Zz9 - (x1*[y])/{q}^2", ")", "[a)", "+a", "a+*b", "a b", "(a)b",
    "a+$b", "a+$-b", "a+$", "(a", "a$", "()", "a(b)", "7"
  };

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  int    fail_count;
  int    beats_owed;
  logic  src_idle;
  int    chars_sent;
  char_t expr_chars[$];

  iesc_char_if   chars_if();
  iesc_status_if results_if();

  infix_expression_syntax_checker uut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (results_if)
  );

  expr_status_checker #(.STACK_DEPTH(STACK_DEPTH_DEF)) status_chk (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars_if),
    .results    (results_if),
    .fail_count (fail_count),
    .beats_owed (beats_owed)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Random letter or digit
  function automatic char_t name_char();
    case ($urandom_range(0, 2))
      0:       return CH_0 + char_t'($urandom_range(0, 9));
      1:       return CH_UA + char_t'($urandom_range(0, 25));
      default: return CH_LA + char_t'($urandom_range(0, 25));
    endcase
  endfunction

  // Random byte weighted toward characters the checker cares about
  function automatic char_t syntax_char();
    case ($urandom_range(0, 5))
      0:       return OPS[$urandom_range(0, 4)];
      1:       return OPENERS[$urandom_range(0, 2)];
      2:       return CLOSERS[$urandom_range(0, 2)];
      3:       return CH_SPACE;
      4:       return name_char();
      default: return char_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Appends one character to the expression being built
  task automatic add_char(input char_t c);
    expr_chars.insert(expr_chars.size(), c);
  endtask

  task automatic pad();
    if ($urandom_range(0, 5) == 0) add_char(CH_SPACE);
  endtask

  // Well-formed expression of some operand terms: random nesting, names of
  // one to four characters, stray spaces between tokens.
  task automatic build_wellformed(input int terms);
    int kinds[$];
    int k;
    expr_chars.delete();
    for (int t = 0; t < terms; t++) begin
      while (kinds.size() < 6 && $urandom_range(0, 3) == 0) begin
        k = $urandom_range(0, 2);
        kinds.insert(kinds.size(), k);
        add_char(OPENERS[k]);
        pad();
      end
      repeat ($urandom_range(1, 4)) add_char(name_char());
      pad();
      while (kinds.size() > 0 && $urandom_range(0, 2) == 0) begin
        add_char(CLOSERS[kinds.pop_back()]);
        pad();
      end
      if (t != terms - 1) begin
        add_char(OPS[$urandom_range(0, 4)]);
        pad();
      end
    end
    while (kinds.size() > 0) add_char(CLOSERS[kinds.pop_back()]);
  endtask

  // Sends expr_chars as one expression, last flag on the final beat. Entered
  // and left just after a falling edge; valid stays high across back-to-back
  // beats and is only lowered when a gap is drawn.
  task automatic send_expr();
    int gap;
    foreach (expr_chars[i]) begin
      gap = src_idle ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
        chars_if.valid     <= 1'b0;
        chars_if.char_code <= char_t'($urandom_range(0, 255));
        chars_if.last_char <= 1'($urandom_range(0, 1));
        repeat (gap) @(negedge clk);
      end
      chars_if.valid     <= 1'b1;
      chars_if.char_code <= expr_chars[i];
      chars_if.last_char <= (i == expr_chars.size() - 1);
      do @(posedge clk); while (!chars_if.ready);
      @(negedge clk);
      chars_sent++;
    end
  endtask

  // Holds the sender off until every owed status beat has come back.
  task automatic wait_drained();
    chars_if.valid <= 1'b0;
    @(negedge clk);
    while (beats_owed != 0) @(negedge clk);
  endtask

  // Character source
  initial begin
    int n_expr;
    int sel;
    int pos;
    int nest;
    int k;
    int kinds[$];
    chars_if.valid     = 1'b0;
    chars_if.char_code = '0;
    chars_if.last_char = 1'b0;
    src_idle   = 1'b1;
    chars_sent = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_exprs[i]) begin
      expr_chars.delete();
      for (int j = 0; j < directed_exprs[i].len(); j++)
        add_char(directed_exprs[i][j]);
      send_expr();
    end
    // High bytes and control codes are plain invalid characters
    expr_chars = '{8'h80, CH_SPACE, 8'hFF};
    send_expr();
    expr_chars = '{8'h00, 8'h7F};
    send_expr();
    wait_drained();

    // Random part: mostly well-formed expressions, some lightly corrupted,
    // some pure noise, and now and then a nest around the stack depth.
    n_expr = 0;
    while (chars_sent < 1800) begin
      src_idle = ($urandom_range(0, 3) != 0);
      if (n_expr % 23 == 11) wait_drained();
      sel = $urandom_range(0, 9);
      if (n_expr % 37 == 5) begin
        // Depth around STACK_DEPTH: exactly full passes, one more overflows
        nest = $urandom_range(STACK_DEPTH_DEF - 2, STACK_DEPTH_DEF + 2);
        expr_chars.delete();
        kinds.delete();
        repeat (nest) begin
          k = $urandom_range(0, 2);
          kinds.insert(kinds.size(), k);
          add_char(OPENERS[k]);
        end
        add_char(name_char());
        while (kinds.size() > 0) add_char(CLOSERS[kinds.pop_back()]);
      end else if (sel == 0) begin
        expr_chars.delete();
        repeat ($urandom_range(1, 10)) add_char(syntax_char());
      end else if (sel < 7) begin
        build_wellformed($urandom_range(1, 6));
      end else begin
        build_wellformed($urandom_range(1, 6));
        repeat ($urandom_range(1, 2)) begin
          pos = $urandom_range(0, expr_chars.size() - 1);
          case ($urandom_range(0, 2))
            0:       expr_chars[pos] = syntax_char();
            1:       expr_chars.insert(pos, syntax_char());
            default: if (expr_chars.size() > 1) expr_chars.delete(pos);
          endcase
        end
      end
      send_expr();
      n_expr++;
    end

    // Each status beat shows in the cycle after its character; a further wait
    // after the drain catches any stray extra beat.
    wait_drained();
    repeat (10) @(negedge clk);
    if (fail_count == 0 && beats_owed == 0) begin
      $display("[infix_expression_syntax_checker] OK");
    end else begin
      $display("[infix_expression_syntax_checker] ERROR");
    end
    $finish;
  end

  // Status sink: per beat a random stall before ready, in bursts that either
  // stall or take every beat at once.
  initial begin
    int   stall;
    int   burst;
    logic snk_idle;
    results_if.ready = 1'b0;
    burst    = 0;
    snk_idle = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (burst == 0) begin
        snk_idle = ($urandom_range(0, 3) != 0);
        burst    = $urandom_range(8, 40);
      end
      burst--;
      stall = snk_idle ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        results_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      results_if.ready <= 1'b1;
      do @(posedge clk); while (!results_if.valid);
      @(negedge clk);
    end
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("[infix_expression_syntax_checker] ERROR");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/iesc_pkg.sv
rtl/iesc_if.sv
rtl/iesc_ram.sv
rtl/infix_expression_syntax_checker.sv
rtl/iesc_checker.sv
verif/expr_status_checker.sv
verif/infix_expression_syntax_checker_tb.sv
